// ===== rtl/rtwg_pkg.sv =====
// Shared types and constants for the gap-coded tag write encoder.
package rtwg_pkg;

  // Width of every timing register on the configuration port.
  localparam int unsigned CFG_W   = 10;
  localparam int unsigned CIDX_W  = 3;

  // Input command codes.
  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_RESET = 2'd2;

  // Configuration register indexes.
  localparam logic [CIDX_W-1:0] CFG_WAIT      = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_START_GAP = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_BIT_GAP   = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_ZERO_ON   = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_ONE_ON    = 3'd4;
  localparam logic [CIDX_W-1:0] CFG_PROGRAM   = 3'd5;

  // Register defaults after reset.
  localparam logic [CFG_W-1:0] RST_WAIT      = 10'd400;
  localparam logic [CFG_W-1:0] RST_START_GAP = 10'd30;
  localparam logic [CFG_W-1:0] RST_BIT_GAP   = 10'd18;
  localparam logic [CFG_W-1:0] RST_ZERO_ON   = 10'd24;
  localparam logic [CFG_W-1:0] RST_ONE_ON    = 10'd56;
  localparam logic [CFG_W-1:0] RST_PROGRAM   = 10'd700;

  // Opcode bits that lead every frame.
  localparam logic [1:0] FRAME_OPCODE = 2'b10;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_WAIT_PRE  = 4'd1,
    PH_START_GAP = 4'd2,
    PH_BITS      = 4'd3,
    PH_PROGRAM   = 4'd4,
    PH_WAIT_POST = 4'd5,
    PH_RST_GAP   = 4'd6,
    PH_RST_BITS  = 4'd7
  } phase_e;

  typedef struct packed {
    logic [CFG_W-1:0] wait_ticks;
    logic [CFG_W-1:0] start_gap_ticks;
    logic [CFG_W-1:0] bit_gap_ticks;
    logic [CFG_W-1:0] zero_on_ticks;
    logic [CFG_W-1:0] one_on_ticks;
    logic [CFG_W-1:0] program_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [2:0]  block_addr;
    logic        lock_flag;
    logic [31:0] block_data;
  } in_item_t;

  typedef struct packed {
    logic carrier_on;
    logic busy_res;
    logic done_res;
    logic rejected;
  } out_item_t;

endpackage

// ===== rtl/rfid_tag_write_gap_encoder_unit.sv =====
// Top level of the gap-coded tag write encoder: command decode, tick sequencer, result register.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-----------------------------------------
//  in      | in        | in_valid_i / in_stall_o  | in_item_i  (mode, addr, lock, data)
//  out     | out       | out_valid_o / out_stall_i| out_item_o (carrier, busy, done, reject)
//  cfg     | in        | cfg_we_i                 | cfg_idx_i, cfg_wdata_i
//
// One field tick per cycle: a tick is taken and its result lands in the output
// register at the same edge, so items stream at one per clock while the input is not stalled.
// Zero-length segments are walked one per cycle by the segment advance unit with
// the input stalled: a result whose tick expires onto them waits until they are walked;
// a start command landing on them is loaded, walked, then given its own tick.
// Reset puts the sequencer idle, the output empty and the registers at defaults.
// Apart from those walks, only a stalled result stalls the input.
module rfid_tag_write_gap_encoder_unit #(
  parameter int unsigned DATA_BITS  = 32,
  parameter int unsigned TICK_WIDTH = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  rtwg_pkg::in_item_t            in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output rtwg_pkg::out_item_t           out_item_o,
  input  logic                          cfg_we_i,
  input  logic [rtwg_pkg::CIDX_W-1:0]   cfg_idx_i,
  input  logic [rtwg_pkg::CFG_W-1:0]    cfg_wdata_i
);
  import rtwg_pkg::*;

  localparam int unsigned FRAME_W = DATA_BITS + 6;
  localparam int unsigned BITS_W  = $clog2(DATA_BITS + 7);

  // RUN takes ticks; PRE walks empty segments before a command tick;
  // TICK runs the held tick; POST walks empty segments after it.
  typedef enum logic [1:0] {
    CTL_RUN,
    CTL_PRE,
    CTL_TICK,
    CTL_POST
  } ctl_e;

  cfg_t cfg;

  // sequencer state
  ctl_e                ctl_q, ctl_d;
  phase_e              phase_q, phase_d;
  logic [TICK_WIDTH-1:0] tick_q, tick_d;
  logic [BITS_W-1:0]   bits_q, bits_d;
  logic [FRAME_W-1:0]  frame_q, frame_d;
  logic                half_q, half_d;

  // pending result while empty segments are walked
  out_item_t           res_q, res_d;
  logic                done_q, done_d;
  out_item_t           out_q, out_d;
  logic                out_valid_q, out_valid_d;

  // state after command decode
  phase_e              b_phase;
  logic [TICK_WIDTH-1:0] b_tick, dec;
  logic [BITS_W-1:0]   b_bits;
  logic [FRAME_W-1:0]  b_frame;
  logic                b_half;

  // segment advance unit in/out
  phase_e              s_phase_in, s_phase;
  logic [TICK_WIDTH-1:0] s_tick_in, s_tick;
  logic [BITS_W-1:0]   s_bits_in, s_bits;
  logic [FRAME_W-1:0]  s_frame_in, s_frame;
  logic                s_half_in, s_half;

  logic rej, active, expire, carrier, need_pre, seg_empty, seg_idle, tick_mode;
  logic in_acc;

  rtwg_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  rtwg_seg_step #(
    .DATA_BITS  (DATA_BITS),
    .TICK_WIDTH (TICK_WIDTH)
  ) u_step (
    .cfg_i   (cfg),
    .phase_i (s_phase_in),
    .tick_i  (s_tick_in),
    .bits_i  (s_bits_in),
    .frame_i (s_frame_in),
    .half_i  (s_half_in),
    .phase_o (s_phase),
    .tick_o  (s_tick),
    .bits_o  (s_bits),
    .frame_o (s_frame),
    .half_o  (s_half)
  );

  // the result register frees up at the same edge it is taken
  assign in_stall_o = (ctl_q != CTL_RUN) || (out_valid_q && out_stall_i);
  assign in_acc     = in_valid_i && !in_stall_o;

  // command decode: a start while idle loads the sequence, while busy it is refused
  always_comb begin
    rej     = 1'b0;
    b_phase = phase_q;
    b_tick  = tick_q;
    b_bits  = bits_q;
    b_frame = frame_q;
    b_half  = half_q;
    if (ctl_q == CTL_RUN &&
        (in_item_i.mode == MODE_WRITE || in_item_i.mode == MODE_RESET)) begin
      if (phase_q != PH_IDLE) begin
        rej = 1'b1;
      end else if (in_item_i.mode == MODE_WRITE) begin
        // address, lock and data park in bits/half/frame until the start gap ends
        b_phase = PH_WAIT_PRE;
        b_tick  = TICK_WIDTH'(cfg.wait_ticks);
        b_bits  = BITS_W'(in_item_i.block_addr);
        b_half  = in_item_i.lock_flag;
        b_frame = FRAME_W'(in_item_i.block_data[DATA_BITS-1:0]);
      end else begin
        b_phase = PH_RST_GAP;
        b_tick  = TICK_WIDTH'(cfg.start_gap_ticks);
      end
    end
  end

  // tick on the decoded state
  assign active   = (b_phase != PH_IDLE);
  assign need_pre = active && (b_tick == '0);
  assign dec      = b_tick - TICK_WIDTH'(1);
  assign expire   = active && (dec == '0);

  always_comb begin
    unique case (b_phase)
      PH_START_GAP, PH_RST_GAP: carrier = 1'b0;
      PH_BITS, PH_RST_BITS:     carrier = !b_half;
      default:                  carrier = 1'b1;
    endcase
  end

  // the advance unit sees the decremented state on a tick, the held state otherwise
  assign tick_mode  = (ctl_q == CTL_RUN) || (ctl_q == CTL_TICK);
  assign s_phase_in = tick_mode ? b_phase : phase_q;
  assign s_tick_in  = tick_mode ? dec     : tick_q;
  assign s_bits_in  = tick_mode ? b_bits  : bits_q;
  assign s_frame_in = tick_mode ? b_frame : frame_q;
  assign s_half_in  = tick_mode ? b_half  : half_q;

  assign seg_idle  = (s_phase == PH_IDLE);
  assign seg_empty = !seg_idle && (s_tick == '0);

  always_comb begin
    ctl_d       = ctl_q;
    phase_d     = phase_q;
    tick_d      = tick_q;
    bits_d      = bits_q;
    frame_d     = frame_q;
    half_d      = half_q;
    res_d       = res_q;
    done_d      = done_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;

    unique case (ctl_q)
      CTL_RUN, CTL_TICK: begin
        if (ctl_q == CTL_TICK || in_acc) begin
          if (ctl_q == CTL_RUN) begin
            res_d.rejected = rej;
            done_d         = 1'b0;
          end
          if (ctl_q == CTL_RUN && need_pre) begin
            // command landed on an empty segment: walk it before the tick
            phase_d = b_phase;
            tick_d  = b_tick;
            bits_d  = b_bits;
            frame_d = b_frame;
            half_d  = b_half;
            ctl_d   = CTL_PRE;
          end else begin
            res_d.carrier_on = carrier;
            res_d.busy_res   = active;
            if (expire) begin
              phase_d = s_phase;
              tick_d  = s_tick;
              bits_d  = s_bits;
              frame_d = s_frame;
              half_d  = s_half;
            end else begin
              phase_d = b_phase;
              tick_d  = active ? dec : b_tick;
              bits_d  = b_bits;
              frame_d = b_frame;
              half_d  = b_half;
            end
            if (expire && seg_empty) begin
              ctl_d = CTL_POST;
            end else begin
              out_d.carrier_on = carrier;
              out_d.busy_res   = active;
              out_d.done_res   = (expire && seg_idle) || (ctl_q == CTL_TICK && done_q);
              out_d.rejected   = (ctl_q == CTL_RUN) ? rej : res_q.rejected;
              out_valid_d      = 1'b1;
              ctl_d            = CTL_RUN;
            end
          end
        end
      end
      CTL_PRE: begin
        phase_d = s_phase;
        tick_d  = s_tick;
        bits_d  = s_bits;
        frame_d = s_frame;
        half_d  = s_half;
        if (!seg_empty) begin
          done_d = seg_idle;
          ctl_d  = CTL_TICK;
        end
      end
      CTL_POST: begin
        phase_d = s_phase;
        tick_d  = s_tick;
        bits_d  = s_bits;
        frame_d = s_frame;
        half_d  = s_half;
        if (!seg_empty) begin
          out_d.carrier_on = res_q.carrier_on;
          out_d.busy_res   = res_q.busy_res;
          out_d.done_res   = seg_idle;
          out_d.rejected   = res_q.rejected;
          out_valid_d      = 1'b1;
          ctl_d            = CTL_RUN;
        end
      end
      default: ctl_d = CTL_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q       <= CTL_RUN;
      phase_q     <= PH_IDLE;
      tick_q      <= '0;
      bits_q      <= '0;
      frame_q     <= '0;
      half_q      <= 1'b0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      ctl_q       <= ctl_d;
      phase_q     <= phase_d;
      tick_q      <= tick_d;
      bits_q      <= bits_d;
      frame_q     <= frame_d;
      half_q      <= half_d;
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payloads, no reset needed
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ===== rtl/rtwg_cfg_regs.sv =====
// Timing register bank written through the plain configuration port.
module rtwg_cfg_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [rtwg_pkg::CIDX_W-1:0] cfg_idx_i,
  input  logic [rtwg_pkg::CFG_W-1:0]  cfg_wdata_i,
  output rtwg_pkg::cfg_t              cfg_o
);
  import rtwg_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wait_ticks      <= RST_WAIT;
      cfg_q.start_gap_ticks <= RST_START_GAP;
      cfg_q.bit_gap_ticks   <= RST_BIT_GAP;
      cfg_q.zero_on_ticks   <= RST_ZERO_ON;
      cfg_q.one_on_ticks    <= RST_ONE_ON;
      cfg_q.program_ticks   <= RST_PROGRAM;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_WAIT:      cfg_q.wait_ticks      <= cfg_wdata_i;
        CFG_START_GAP: cfg_q.start_gap_ticks <= cfg_wdata_i;
        CFG_BIT_GAP:   cfg_q.bit_gap_ticks   <= cfg_wdata_i;
        CFG_ZERO_ON:   cfg_q.zero_on_ticks   <= cfg_wdata_i;
        CFG_ONE_ON:    cfg_q.one_on_ticks    <= cfg_wdata_i;
        CFG_PROGRAM:   cfg_q.program_ticks   <= cfg_wdata_i;
        default:       ; // unmapped index, write dropped
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/rtwg_seg_step.sv =====
// Segment advance: moves the sequencer state on to the following segment.
module rtwg_seg_step #(
  parameter int unsigned DATA_BITS  = 32,
  parameter int unsigned TICK_WIDTH = 10
) (
  input  rtwg_pkg::cfg_t                         cfg_i,
  input  rtwg_pkg::phase_e                       phase_i,
  input  logic [TICK_WIDTH-1:0]                  tick_i,
  input  logic [$clog2(DATA_BITS+7)-1:0]         bits_i,
  input  logic [DATA_BITS+5:0]                   frame_i,
  input  logic                                   half_i,
  output rtwg_pkg::phase_e                       phase_o,
  output logic [TICK_WIDTH-1:0]                  tick_o,
  output logic [$clog2(DATA_BITS+7)-1:0]         bits_o,
  output logic [DATA_BITS+5:0]                   frame_o,
  output logic                                   half_o
);
  import rtwg_pkg::*;

  localparam int unsigned FRAME_W = DATA_BITS + 6;
  localparam int unsigned BITS_W  = $clog2(DATA_BITS + 7);

  logic [TICK_WIDTH-1:0] wait_t, sgap_t, bgap_t, zero_t, one_t, prog_t;
  logic [BITS_W-1:0]     bits_dec;
  logic [FRAME_W-1:0]    frame_sh;
  logic                  load_on;

  assign wait_t = TICK_WIDTH'(cfg_i.wait_ticks);
  assign sgap_t = TICK_WIDTH'(cfg_i.start_gap_ticks);
  assign bgap_t = TICK_WIDTH'(cfg_i.bit_gap_ticks);
  assign zero_t = TICK_WIDTH'(cfg_i.zero_on_ticks);
  assign one_t  = TICK_WIDTH'(cfg_i.one_on_ticks);
  assign prog_t = TICK_WIDTH'(cfg_i.program_ticks);

  assign bits_dec = bits_i - BITS_W'(1);
  assign frame_sh = {frame_i[FRAME_W-2:0], 1'b0};

  always_comb begin
    phase_o = phase_i;
    tick_o  = tick_i;
    bits_o  = bits_i;
    frame_o = frame_i;
    half_o  = half_i;
    load_on = 1'b0;
    unique case (phase_i)
      PH_WAIT_PRE: begin
        phase_o = PH_START_GAP;
        tick_o  = sgap_t;
      end
      PH_START_GAP: begin
        // parked operands are assembled into the frame here
        phase_o = PH_BITS;
        frame_o = {FRAME_OPCODE, half_i, frame_i[DATA_BITS-1:0], bits_i[2:0]};
        bits_o  = BITS_W'(DATA_BITS + 6);
        half_o  = 1'b0;
        load_on = 1'b1;
      end
      PH_BITS, PH_RST_BITS: begin
        if (!half_i) begin
          half_o = 1'b1;
          tick_o = bgap_t;
        end else begin
          frame_o = frame_sh;
          bits_o  = bits_dec;
          half_o  = 1'b0;
          if (bits_dec != '0) begin
            load_on = 1'b1;
          end else if (phase_i == PH_BITS) begin
            phase_o = PH_PROGRAM;
            tick_o  = prog_t;
          end else begin
            phase_o = PH_IDLE;
            tick_o  = '0;
          end
        end
      end
      PH_PROGRAM: begin
        phase_o = PH_WAIT_POST;
        tick_o  = wait_t;
      end
      PH_WAIT_POST: begin
        phase_o = PH_RST_GAP;
        tick_o  = sgap_t;
      end
      PH_RST_GAP: begin
        phase_o = PH_RST_BITS;
        frame_o = {FRAME_OPCODE, {(FRAME_W-2){1'b0}}};
        bits_o  = BITS_W'(2);
        half_o  = 1'b0;
        load_on = 1'b1;
      end
      default: begin
        phase_o = PH_IDLE;
        tick_o  = '0;
        bits_o  = '0;
        half_o  = 1'b0;
      end
    endcase
    // on-part length follows the bit now at the head of the frame
    if (load_on) begin
      tick_o = frame_o[FRAME_W-1] ? one_t : zero_t;
    end
  end

endmodule

// ===== rtl/rtwg_checker.sv =====
// Port-level checks for the gap-coded tag write encoder, bound to the top level.
module rtwg_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input rtwg_pkg::out_item_t           out_item_o
);

  // a refused command still advances a running sequence
  a_rej_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.rejected |-> out_item_o.busy_res)
    else $error("rejected command reported on an idle tick");

  // field stays driven while idle
  a_idle_carrier: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.busy_res |-> out_item_o.carrier_on)
    else $error("carrier gapped while idle");

  // a stalled result holds off new ticks
  a_back_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input taken while result stalled");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

endmodule

bind rfid_tag_write_gap_encoder_unit rtwg_checker u_rtwg_checker (.*);
